// ===== hw/rtl/sha256_counter_keystream_xor_defines.svh =====
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef SHA256_COUNTER_KEYSTREAM_XOR_DEFINES_SVH
`define SHA256_COUNTER_KEYSTREAM_XOR_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SKX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define SKX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hw/rtl/skx_pkg.sv =====
// Shared types, constants and SHA-256 helper functions.
// No dependencies.
`default_nettype none
package skx_pkg;
  localparam int unsigned KsBytes    = 32;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned Rounds     = 64;

  typedef enum logic [CfgIdxW-1:0] {
    RegKey0 = 3'd0, RegKey1 = 3'd1, RegKey2 = 3'd2, RegKey3 = 3'd3,
    RegNonceLo = 3'd4, RegNonceHi = 3'd5
  } cfg_reg_e;

  // One classified byte: data, last flag, whether a new block starts here and byte position.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       refill;
    logic [4:0] pos;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] counter;
  } hash_req_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  localparam logic [255:0] InitH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/skx_stream_if.sv =====
// Valid/ready channel interface with a parameterized payload type.
// Depends on nothing.
`default_nettype none
interface skx_stream_if #(parameter type payload_t = logic [8:0]);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/skx_front.sv =====
// Front end: accepts bytes, tracks byte position and marks block refills.
// Depends on skx_pkg.
`default_nettype none
module skx_front import skx_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_i,
  input  wire logic       last_i,
  output logic            push_o,
  output item_t           item_o,
  input  wire logic       full_i
);
  logic [4:0] pos_q, pos_d;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    item_o.data   = data_i;
    item_o.last   = last_i;
    item_o.refill = (pos_q == 5'd0);
    item_o.pos    = pos_q;
    pos_d = pos_q;
    if (push_o) begin
      pos_d = last_i ? 5'd0 : pos_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/skx_queue.sv =====
// Small FIFO of classified items between front and back.
// Depends on skx_pkg.
`default_nettype none
module skx_queue import skx_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output item_t      item_o
);
  localparam int unsigned AW = $clog2(Depth);
  item_t        mem_q [Depth];
  logic [AW:0]  wr_q, rd_q;

  assign empty_o = (wr_q == rd_q);
  assign full_o  = (wr_q[AW-1:0] == rd_q[AW-1:0]) && (wr_q[AW] != rd_q[AW]);
  assign item_o  = mem_q[rd_q[AW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q[AW-1:0]] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/skx_hash.sv =====
// Iterative SHA-256 core: one round per cycle over the fixed 52-byte message.
// Depends on skx_pkg.
`default_nettype none
module skx_hash import skx_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  hash_req_t         req_i,
  input  wire logic [255:0] key_i,
  input  wire logic [95:0]  nonce_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [255:0]      digest_o
);
  logic [31:0]  w_q [16];
  logic [31:0]  s_q [8];
  logic [6:0]   rnd_q;
  logic         busy_q, done_q;
  logic [511:0] blk;
  logic [31:0]  w_new, t1, t2, e1, a0, ch, mj, s0, s1, wcur;

  // Build the padded block; bytes are little-endian within each register.
  always_comb begin
    blk = '0;
    for (int i = 0; i < 32; i++) blk[511-8*i -: 8] = key_i[8*i +: 8];
    for (int i = 0; i < 12; i++) blk[255-8*i -: 8] = nonce_i[8*i +: 8];
    for (int i = 0; i < 8; i++)  blk[159-8*i -: 8] = req_i.counter[8*i +: 8];
    blk[95:88] = 8'h80;
    blk[15:0]  = 16'd416;
  end

  assign wcur  = w_q[0];
  assign s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign w_new = w_q[0] + s0 + w_q[9] + s1;
  assign e1    = rotr(s_q[4], 6) ^ rotr(s_q[4], 11) ^ rotr(s_q[4], 25);
  assign ch    = (s_q[4] & s_q[5]) ^ (~s_q[4] & s_q[6]);
  assign t1    = s_q[7] + e1 + ch + round_k(rnd_q[5:0]) + wcur;
  assign a0    = rotr(s_q[0], 2) ^ rotr(s_q[0], 13) ^ rotr(s_q[0], 22);
  assign mj    = (s_q[0] & s_q[1]) ^ (s_q[0] & s_q[2]) ^ (s_q[1] & s_q[2]);
  assign t2    = a0 + mj;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      digest_o[255-32*i -: 32] = InitH[255-32*i -: 32] + s_q[i];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      for (int i = 0; i < 16; i++) w_q[i] <= blk[511-32*i -: 32];
      for (int i = 0; i < 8; i++)  s_q[i] <= InitH[255-32*i -: 32];
    end else if (busy_q) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
      s_q[7] <= s_q[6]; s_q[6] <= s_q[5]; s_q[5] <= s_q[4];
      s_q[4] <= s_q[3] + t1;
      s_q[3] <= s_q[2]; s_q[2] <= s_q[1]; s_q[1] <= s_q[0];
      s_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 7'd1;
        if (rnd_q == 7'(Rounds - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/skx_back.sv =====
// Back end: runs block refills, holds the keystream block, XORs and outputs.
// Depends on skx_pkg and skx_hash.
`default_nettype none
module skx_back import skx_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         empty_i,
  input  item_t             item_i,
  output logic              pop_o,
  input  wire logic [255:0] key_i,
  input  wire logic [95:0]  nonce_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [7:0]        data_o,
  output logic              last_o
);
  logic [255:0] ks_q;
  logic         ks_ok_q;     // a freshly hashed block waits for the next refill item
  logic [63:0]  ctr_q;
  logic         ov_q;
  logic [7:0]   od_q;
  logic         ol_q;
  hash_req_t    req;
  logic         busy, done;
  logic [255:0] digest;
  logic         can_emit, slot_free;

  skx_hash u_hash (
    .clk_i, .rst_ni, .req_i(req), .key_i, .nonce_i,
    .busy_o(busy), .done_o(done), .digest_o(digest)
  );

  assign slot_free = !ov_q || out_ready_i;
  // A refill item waits until its block is hashed.
  assign can_emit  = !empty_i && (!item_i.refill || ks_ok_q) && slot_free;
  assign pop_o     = can_emit;
  assign req.start   = !empty_i && item_i.refill && !ks_ok_q && !busy && !done;
  assign req.counter = ctr_q;

  assign out_valid_o = ov_q;
  assign data_o      = od_q;
  assign last_o      = ol_q;

  always_ff @(posedge clk_i) begin
    if (done) ks_q <= digest;
    if (can_emit) begin
      od_q <= item_i.data ^ ks_q[255-8*item_i.pos -: 8];
      ol_q <= item_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ks_ok_q <= 1'b0;
      ctr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (done) begin
        ks_ok_q <= 1'b1;
        ctr_q   <= ctr_q + 64'd1;
      end else if (can_emit && item_i.refill) begin
        ks_ok_q <= 1'b0;
      end
      if (can_emit && item_i.last) begin
        ctr_q <= '0;
      end
      if (can_emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/sha256_counter_keystream_xor.sv =====
// SHA-256 counter-mode keystream XOR, one byte per transfer. Keystream block n
// = SHA-256(key || nonce || n as 64-bit little-endian); a byte with last set
// returns counter and byte position to zero. With no output stall, a
// byte that starts a block (byte position 0) waits at the queue head while a
// single iterative core hashes the block: a start step, 64 rounds at one per
// cycle and a digest capture, after which it leaves. Bytes 1..31 of the block
// then leave at one per cycle while they wait in the queue. A byte that needs
// no refill passes through a queue entry and then the output register. The
// hash starts only when the refill byte reaches the queue head; it never runs
// ahead of the previous block's bytes. The front end accepts bytes into a
// 4-entry queue while the hash runs; the back end XORs with the digest and
// registers the result, so input transfers continue while a result waits,
// until the queue is full. Configuration writes take effect at the next
// block computed.
// Depends on skx_pkg, skx_stream_if, skx_front, skx_queue, skx_back.
`default_nettype none
module sha256_counter_keystream_xor import skx_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  skx_stream_if.sink               in_if,
  skx_stream_if.source             out_if,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);
  logic [255:0] key_q;
  logic [95:0]  nonce_q;
  logic         push, full, pop, empty;
  item_t        fitem, qitem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      nonce_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegKey0:    key_q[63:0]    <= cfg_data_i;
        RegKey1:    key_q[127:64]  <= cfg_data_i;
        RegKey2:    key_q[191:128] <= cfg_data_i;
        RegKey3:    key_q[255:192] <= cfg_data_i;
        RegNonceLo: nonce_q[63:0]  <= cfg_data_i;
        RegNonceHi: nonce_q[95:64] <= cfg_data_i[31:0];
        default: ;  // writes beyond the map are dropped
      endcase
    end
  end

  skx_front u_front (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .data_i(in_if.payload[8:1]), .last_i(in_if.payload[0]),
    .push_o(push), .item_o(fitem), .full_i(full)
  );

  skx_queue #(.Depth(QDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .item_i(fitem), .full_o(full),
    .pop_i(pop), .empty_o(empty), .item_o(qitem)
  );

  skx_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .item_i(qitem), .pop_o(pop),
    .key_i(key_q), .nonce_i(nonce_q), .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready), .data_o(out_if.payload[8:1]),
    .last_o(out_if.payload[0])
  );
endmodule
`default_nettype wire

// ===== hw/rtl/skx_checker.sv =====
// Port-level checker for the keystream XOR block, bound to the top level.
// Depends on the defines header.
`default_nettype none
`include "sha256_counter_keystream_xor_defines.svh"
module skx_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [8:0] out_payload_i
);
  `SKX_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "out dropped")
  `SKX_ASSERT_NEXT(a_pay_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_payload_i), "payload moved")
  `SKX_ASSERT_IMPL(a_ready_known, clk_i, rst_ni, in_valid_i, !$isunknown(in_ready_i), "ready unknown")
endmodule
bind sha256_counter_keystream_xor skx_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_payload_i(out_if.payload)
);
`default_nettype wire
